[hw/rtl/wms_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wms_pkg
// types and constants shared by the window statistics block
// ---------------------------------------------------------------------------
package wms_pkg;

  localparam int unsigned LEN_W = 11;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_FIRST_PHASE  = 2'd0,
    REG_FIRST_LEN    = 2'd1,
    REG_SECOND_LEN   = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_MDIV_GO,
    ST_MDIV_WAIT,
    ST_DEV_RD,
    ST_DEV_LD,
    ST_MUL,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_ROOT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] score_sample;
    logic [15:0]        run_depth;
    logic               limit_exceeded;
  } in_item_t;

  typedef struct packed {
    logic               window_done;
    logic               done_phase;
    logic signed [31:0] mean_score;
    logic [31:0]        score_stddev;
    logic [15:0]        deepest_depth;
  } out_item_t;

endpackage

[hw/rtl/window_mean_stddev_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// window_mean_stddev_unit
// windowed population mean and standard deviation of score samples
// ---------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid_i/in_stall_o   | in_item_i (wms_pkg::in_item_t)
//  out      | output    | out_valid_o/out_stall_i | out_item_o (wms_pkg::out_item_t)
//  cfg      | input     | psel/penable/pwrite | paddr, pwdata, prdata
//
//  an item that does not close a window: accept, then one result transfer
//  a closing item sums the window and divides by its length L into the mean; the squared
//  deviations are summed by the serial multiplier, divided by L and square-rooted
//  no clearing pass after reset; the store is only read where it was written
//  in_stall_o stays high while a window is computed or a result waits
module window_mean_stddev_unit #(
  parameter int unsigned MAX_SAMPLES  = 1024,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wms_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wms_pkg::out_item_t                  out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wms_pkg::APB_AW-1:0]          paddr,
  input  logic [wms_pkg::APB_DW-1:0]          pwdata,
  output logic [wms_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import wms_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = SW + CNT_W;
  localparam int unsigned ACC_W  = 2 * SW + CNT_W;
  localparam int unsigned DIV_W  = (ACC_W > 64) ? ACC_W : 64;
  localparam int unsigned MUL_CW = $clog2(SW);

  // configuration
  logic             phase_q;
  logic [LEN_W-1:0] len1_q, len2_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b1;
      len1_q  <= LEN_W'(1024);
      len2_q  <= LEN_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FIRST_PHASE: phase_q <= pwdata[0];
        REG_FIRST_LEN:   len1_q  <= pwdata[LEN_W-1:0];
        REG_SECOND_LEN:  len2_q  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FIRST_PHASE: prdata = {{(APB_DW-1){1'b0}}, phase_q};
      REG_FIRST_LEN:   prdata = {{(APB_DW-LEN_W){1'b0}}, len1_q};
      REG_SECOND_LEN:  prdata = {{(APB_DW-LEN_W){1'b0}}, len2_q};
      default:         prdata = '0;
    endcase
  end

  // control and datapath state
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, len_q;
  logic [IDX_W-1:0]    idx_q;
  logic [15:0]         max_q;
  logic                wphase_q;
  logic                out_valid_q;
  out_item_t           out_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                neg_q;
  logic [SW-1:0]       mean_q;
  logic [31:0]         mean_out_q;
  logic [2*SW-1:0]     mcand_q, prod_q;
  logic [SW-1:0]       mplier_q;
  logic [MUL_CW-1:0]   mcnt_q;
  logic [ACC_W-1:0]    acc_q;
  logic                vsat_q;
  logic [63:0]         rx_q;
  logic [34:0]         rrem_q;
  logic [31:0]         root_q;
  logic [4:0]          rcnt_q;

  logic              accept;
  logic [LEN_W-1:0]  len_sel;
  logic [CNT_W-1:0]  len_eff, cnt_new;
  logic              room, closes, last_idx, mul_last;
  logic [63:0]       raw64;
  logic [SW-1:0]     samp, rdata;
  logic [SUM_W-1:0]  mag;
  logic [DIV_W-1:0]  div_q, div_dividend;
  logic              div_start, div_busy;
  logic [2*SW-1:0]   prod_nx;
  logic signed [SW:0] diff;
  logic [SW-1:0]     dmag;
  logic [63:0]       mean64;
  logic [34:0]       rtry, rsh;
  logic              rfit;

  assign in_stall_o = (state_q != ST_IDLE) || out_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  assign len_sel = phase_q ? len1_q : len2_q;
  always_comb begin
    if (len_sel == '0) begin
      len_eff = CNT_W'(1);
    end else if (32'(len_sel) > 32'(MAX_SAMPLES)) begin
      len_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      len_eff = CNT_W'(len_sel);
    end
  end

  assign room    = count_q < CNT_W'(MAX_SAMPLES);
  assign cnt_new = room ? count_q + 1'b1 : count_q;
  assign closes  = cnt_new >= len_eff;
  assign raw64   = {32'd0, in_item_i.score_sample};
  assign samp    = raw64[SW-1:0];
  assign last_idx = (CNT_W'(idx_q) + 1'b1) == len_q;
  assign mul_last = mcnt_q == MUL_CW'(SW - 1);

  wms_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && room),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (samp),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  wms_div #(.DIVIDEND_W(DIV_W), .DIVISOR_W(CNT_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (len_q),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  assign mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign prod_nx = mplier_q[0] ? prod_q + mcand_q : prod_q;
  assign diff    = $signed({rdata[SW-1], rdata}) - $signed({mean_q[SW-1], mean_q});
  assign dmag    = diff[SW] ? SW'(-diff) : SW'(diff);
  assign mean64  = {{(64-SW){mean_q[SW-1]}}, mean_q};
  assign rsh     = {rrem_q[32:0], rx_q[63:62]};
  assign rtry    = {1'b0, root_q, 2'b01};
  assign rfit    = rsh >= rtry;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (accept && closes) state_d = ST_SUM_RD;
      ST_SUM_RD:    state_d = ST_SUM_ACC;
      ST_SUM_ACC:   state_d = last_idx ? ST_MDIV_GO : ST_SUM_RD;
      ST_MDIV_GO:   state_d = ST_MDIV_WAIT;
      ST_MDIV_WAIT: if (!div_busy) state_d = ST_DEV_RD;
      ST_DEV_RD:    state_d = ST_DEV_LD;
      ST_DEV_LD:    state_d = ST_MUL;
      ST_MUL:       if (mul_last) state_d = last_idx ? ST_VDIV_GO : ST_DEV_RD;
      ST_VDIV_GO:   state_d = ST_VDIV_WAIT;
      ST_VDIV_WAIT: if (!div_busy) state_d = ST_ROOT;
      ST_ROOT:      if (rcnt_q == 5'd31) state_d = ST_OUT;
      ST_OUT:       state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(acc_q);
    unique case (state_q)
      ST_MDIV_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(mag);
      end
      ST_VDIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      len_q       <= '0;
      wphase_q    <= 1'b0;
      mcnt_q      <= '0;
      rcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!in_item_i.limit_exceeded && in_item_i.run_depth > max_q) begin
              max_q <= in_item_i.run_depth;
            end
            if (closes) begin
              count_q  <= '0;
              len_q    <= len_eff;
              wphase_q <= phase_q;
              idx_q    <= '0;
            end else begin
              count_q     <= cnt_new;
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_SUM_ACC: if (!last_idx) idx_q <= idx_q + 1'b1;
        ST_MDIV_WAIT: if (!div_busy) idx_q <= '0;
        ST_DEV_LD: mcnt_q <= '0;
        ST_MUL: begin
          mcnt_q <= mcnt_q + 1'b1;
          if (mul_last && !last_idx) idx_q <= idx_q + 1'b1;
        end
        ST_VDIV_WAIT: rcnt_q <= '0;
        ST_ROOT: rcnt_q <= rcnt_q + 1'b1;
        ST_OUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        sum_q <= '0;
        acc_q <= '0;
        if (accept) begin
          out_q.window_done  <= 1'b0;
          out_q.done_phase   <= 1'b0;
          out_q.mean_score   <= '0;
          out_q.score_stddev <= '0;
          out_q.deepest_depth <=
            (!in_item_i.limit_exceeded && in_item_i.run_depth > max_q) ?
            in_item_i.run_depth : max_q;
        end
      end
      ST_SUM_ACC: sum_q <= sum_q + $signed({{CNT_W{rdata[SW-1]}}, rdata});
      ST_MDIV_GO: neg_q <= sum_q[SUM_W-1];
      ST_MDIV_WAIT: begin
        if (!div_busy) begin
          mean_q <= neg_q ? SW'(-div_q[SW-1:0]) : div_q[SW-1:0];
        end
      end
      ST_DEV_RD: begin
        if (neg_q && div_q > DIV_W'(64'h8000_0000)) begin
          mean_out_q <= 32'h8000_0000;
        end else if (!neg_q && div_q > DIV_W'(64'h7FFF_FFFF)) begin
          mean_out_q <= 32'h7FFF_FFFF;
        end else begin
          mean_out_q <= mean64[31:0];
        end
      end
      ST_DEV_LD: begin
        mcand_q  <= (2*SW)'(dmag);
        mplier_q <= dmag;
        prod_q   <= '0;
      end
      ST_MUL: begin
        prod_q   <= prod_nx;
        mcand_q  <= {mcand_q[2*SW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[SW-1:1]};
        if (mul_last) acc_q <= acc_q + ACC_W'(prod_nx);
      end
      ST_VDIV_WAIT: begin
        vsat_q <= (div_q >> 64) != '0;
        rx_q   <= div_q[63:0];
        rrem_q <= '0;
        root_q <= '0;
      end
      ST_ROOT: begin
        rx_q   <= {rx_q[61:0], 2'b00};
        rrem_q <= rfit ? rsh - rtry : rsh;
        root_q <= {root_q[30:0], rfit};
      end
      ST_OUT: begin
        out_q.window_done  <= 1'b1;
        out_q.done_phase   <= wphase_q;
        out_q.mean_score   <= mean_out_q;
        out_q.score_stddev <= vsat_q ? 32'hFFFF_FFFF : root_q;
        out_q.deepest_depth <= max_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hw/rtl/wms_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wms_ram
// single write port, single registered read port memory
// ---------------------------------------------------------------------------
module wms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hw/rtl/wms_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wms_div
// restoring divider, one quotient bit per cycle, floor quotient
// ---------------------------------------------------------------------------
module wms_div #(
  parameter int unsigned DIVIDEND_W = 64,
  parameter int unsigned DIVISOR_W  = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(DIVIDEND_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quotient_o = quo_q;

endmodule

[hw/rtl/wms_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wms_checker
// port level checks for the window statistics block
// ---------------------------------------------------------------------------
module wms_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input wms_pkg::out_item_t  out_item_o
);
  import wms_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped or changed under stall");

  // one item at a time: after a transfer in, the input is held off
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item pending");

  // a result is never offered while the input is open
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("result pending while input open");

  // no window closed means zero statistics
  a_zero_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.window_done |->
      out_item_o.mean_score == '0 && out_item_o.score_stddev == '0 &&
      !out_item_o.done_phase)
    else $error("statistics without closed window");

endmodule

bind window_mean_stddev_unit wms_checker u_wms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
